// ===== hdl/tidv_pkg.sv =====
// ----------------------------------------------------------------------------
// tidv_pkg
// Shared types, constants and weight tables for the tax identifier
// check-digit validator.
// ----------------------------------------------------------------------------
`default_nettype none

package tidv_pkg;

    typedef enum logic {
        KIND_CPF  = 1'b0,
        KIND_CNPJ = 1'b1
    } kind_t;

    localparam logic [7:0] DIGIT_ZERO  = 8'd48;
    localparam logic [7:0] DIGIT_NINE  = 8'd57;

    localparam logic [4:0] CNPJ_LIMIT  = 5'd19;
    localparam logic [4:0] CPF_LIMIT   = 5'd14;
    localparam logic [4:0] POS_MAX     = 5'd31;

    localparam logic [3:0] CNPJ_N1     = 4'd12;
    localparam logic [3:0] CPF_N1      = 4'd9;
    localparam logic [3:0] CNPJ_NEED   = 4'd14;
    localparam logic [3:0] CPF_NEED    = 4'd11;
    localparam logic [3:0] REPEAT_SPAN = 4'd11;
    localparam logic [3:0] INDEX_MAX   = 4'd15;

    localparam logic [3:0] MOD_BASE    = 4'd11;
    // floor(s / 11) = (s * 1490) >> 14, exact for any 10-bit s
    localparam logic [10:0] RECIP_MUL  = 11'd1490;
    localparam int RECIP_SHIFT         = 14;

    localparam logic [3:0] CNPJ_W1 [12] = '{4'd5, 4'd4, 4'd3, 4'd2, 4'd9, 4'd8,
                                            4'd7, 4'd6, 4'd5, 4'd4, 4'd3, 4'd2};
    localparam logic [3:0] CNPJ_W2 [13] = '{4'd6, 4'd5, 4'd4, 4'd3, 4'd2, 4'd9, 4'd8,
                                            4'd7, 4'd6, 4'd5, 4'd4, 4'd3, 4'd2};
    localparam logic [3:0] CPF_W1 [9]   = '{4'd10, 4'd9, 4'd8, 4'd7, 4'd6,
                                            4'd5, 4'd4, 4'd3, 4'd2};
    localparam logic [3:0] CPF_W2 [10]  = '{4'd11, 4'd10, 4'd9, 4'd8, 4'd7,
                                            4'd6, 4'd5, 4'd4, 4'd3, 4'd2};

    // Snapshot of the running sums at the end of one identifier
    typedef struct packed {
        kind_t      kind;
        logic [9:0] first_sum;
        logic [9:0] second_sum;
        logic [3:0] first_check_digit;
        logic [3:0] second_check_digit;
        logic [3:0] digit_index;
        logic       repeat_match;
    } snap_t;

    function automatic logic [3:0] weight1(kind_t kind, logic [3:0] j);
        logic [3:0] w;
        w = 4'd0;
        if (kind == KIND_CNPJ) begin
            if (j < 4'd12)
            begin
                w = CNPJ_W1[j];
            end
        end
        else if (j < 4'd9)
        begin
            w = CPF_W1[j];
        end
        return w;
    endfunction

    function automatic logic [3:0] weight2(kind_t kind, logic [3:0] j);
        logic [3:0] w;
        w = 4'd0;
        if (kind == KIND_CNPJ) begin
            if (j < 4'd13)
            begin
                w = CNPJ_W2[j];
            end
        end
        else if (j < 4'd10)
        begin
            w = CPF_W2[j];
        end
        return w;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/tidv_accum.sv =====
// ----------------------------------------------------------------------------
// tidv_accum
// Running per-identifier state: position, digit count, weighted sums, check
// digits and repeated-digit tracking. Emits the updated state as a snapshot.
// ----------------------------------------------------------------------------
`default_nettype none

module tidv_accum
    import tidv_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       step,
    input  wire logic [7:0] char_in,
    input  wire logic       last_char,
    input  kind_t           kind,
    output snap_t           snap
);

    logic [4:0] pos_reg,  pos_next;
    logic [3:0] idx_reg,  idx_next;
    logic [9:0] fs_reg,   fs_next;
    logic [9:0] ss_reg,   ss_next;
    logic [3:0] fcd_reg,  fcd_next;
    logic [3:0] scd_reg,  scd_next;
    logic [3:0] lead_reg, lead_next;
    logic       rep_reg,  rep_next;

    logic       cnpj, is_digit, skip, take;
    logic [4:0] limit;
    logic [3:0] n1, n1p1, d;
    logic [7:0] off, prod1, prod2;
    logic [9:0] fs_upd, ss_upd;
    logic [3:0] fcd_upd, scd_upd, lead_upd, idx_upd;
    logic       rep_upd;

    always_comb
    begin
        cnpj     = (kind == KIND_CNPJ);
        limit    = cnpj ? CNPJ_LIMIT : CPF_LIMIT;
        is_digit = (char_in >= DIGIT_ZERO) && (char_in <= DIGIT_NINE);
        skip     = cnpj && (pos_reg == 5'd2 || pos_reg == 5'd6 ||
                            pos_reg == 5'd10 || pos_reg == 5'd15);
        take     = (pos_reg < limit) && !skip && is_digit;
        off      = char_in - DIGIT_ZERO;
        d        = off[3:0];
        n1       = cnpj ? CNPJ_N1 : CPF_N1;
        n1p1     = n1 + 4'd1;
        prod1    = {4'd0, d} * {4'd0, weight1(kind, idx_reg)};
        prod2    = {4'd0, d} * {4'd0, weight2(kind, idx_reg)};

        fs_upd   = fs_reg;
        ss_upd   = ss_reg;
        fcd_upd  = fcd_reg;
        scd_upd  = scd_reg;
        lead_upd = lead_reg;
        rep_upd  = rep_reg;
        idx_upd  = idx_reg;

        if (take) begin
            if (idx_reg < n1)
            begin
                fs_upd = fs_reg + {2'd0, prod1};
            end
            else if (idx_reg == n1)
            begin
                fcd_upd = d;
            end
            if (idx_reg < n1p1)
            begin
                ss_upd = ss_reg + {2'd0, prod2};
            end
            else if (idx_reg == n1p1)
            begin
                scd_upd = d;
            end
            if (idx_reg == 4'd0)
            begin
                lead_upd = d;
            end
            else if (idx_reg < REPEAT_SPAN && d != lead_reg)
            begin
                rep_upd = 1'b0;
            end
            if (idx_reg < INDEX_MAX)
            begin
                idx_upd = idx_reg + 4'd1;
            end
        end

        snap.kind               = kind;
        snap.first_sum          = fs_upd;
        snap.second_sum         = ss_upd;
        snap.first_check_digit  = fcd_upd;
        snap.second_check_digit = scd_upd;
        snap.digit_index        = idx_upd;
        snap.repeat_match       = rep_upd;

        // Hold unless a character advances; clear after the final one
        pos_next  = pos_reg;
        idx_next  = idx_reg;
        fs_next   = fs_reg;
        ss_next   = ss_reg;
        fcd_next  = fcd_reg;
        scd_next  = scd_reg;
        lead_next = lead_reg;
        rep_next  = rep_reg;
        if (step) begin
            if (last_char) begin
                pos_next  = 5'd0;
                idx_next  = 4'd0;
                fs_next   = 10'd0;
                ss_next   = 10'd0;
                fcd_next  = 4'd0;
                scd_next  = 4'd0;
                lead_next = 4'd0;
                rep_next  = 1'b1;
            end
            else begin
                pos_next  = (pos_reg < POS_MAX) ? pos_reg + 5'd1 : pos_reg;
                idx_next  = idx_upd;
                fs_next   = fs_upd;
                ss_next   = ss_upd;
                fcd_next  = fcd_upd;
                scd_next  = scd_upd;
                lead_next = lead_upd;
                rep_next  = rep_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pos_reg  <= 5'd0;
            idx_reg  <= 4'd0;
            fs_reg   <= 10'd0;
            ss_reg   <= 10'd0;
            fcd_reg  <= 4'd0;
            scd_reg  <= 4'd0;
            lead_reg <= 4'd0;
            rep_reg  <= 1'b1;
        end
        else begin
            pos_reg  <= pos_next;
            idx_reg  <= idx_next;
            fs_reg   <= fs_next;
            ss_reg   <= ss_next;
            fcd_reg  <= fcd_next;
            scd_reg  <= scd_next;
            lead_reg <= lead_next;
            rep_reg  <= rep_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/tidv_check.sv =====
// ----------------------------------------------------------------------------
// tidv_check
// Final decision: mod-11 check of both sums against the check digits plus
// the rejection rules of each identifier kind.
// ----------------------------------------------------------------------------
`default_nettype none

module tidv_check
    import tidv_pkg::*;
(
    input  snap_t      snap,
    output logic       id_valid
);

    // Remainder by reciprocal multiply, then compare with the check digit
    function automatic logic digit_ok(logic [9:0] s, logic [3:0] cd);
        logic [20:0] prod;
        logic [20:0] quot;
        logic [6:0]  q;
        logic [9:0]  qx11;
        logic [9:0]  rem;
        logic [3:0]  r;
        logic [3:0]  exp_digit;
        prod      = {11'd0, s} * {10'd0, RECIP_MUL};
        quot      = prod >> RECIP_SHIFT;
        q         = quot[6:0];
        qx11      = {q, 3'd0} + {2'd0, q, 1'd0} + {3'd0, q};
        rem       = s - qx11;
        r         = rem[3:0];
        exp_digit = (r < 4'd2) ? 4'd0 : MOD_BASE - r;
        return cd == exp_digit;
    endfunction

    logic cnpj;
    logic [3:0] need;

    always_comb
    begin
        cnpj     = (snap.kind == KIND_CNPJ);
        need     = cnpj ? CNPJ_NEED : CPF_NEED;
        id_valid = (snap.digit_index >= need)
                && digit_ok(snap.first_sum, snap.first_check_digit)
                && digit_ok(snap.second_sum, snap.second_check_digit)
                && !(cnpj && snap.first_sum == 10'd0)
                && !(!cnpj && snap.repeat_match);
    end

endmodule

`default_nettype wire

// ===== hdl/tax_id_check_digit_validator.sv =====
// ----------------------------------------------------------------------------
// tax_id_check_digit_validator
// Mod-11 check-digit validator for formatted CPF / CNPJ identifiers.
// ----------------------------------------------------------------------------
// The block takes one ASCII character of a formatted identifier per item on
// the slave stream, one item every clock cycle while s_tready is high, and
// returns one item on the master stream for each character marked with
// tlast. Digit characters are counted and folded into two weighted sums as
// they arrive; for CNPJ the separator positions 2, 6, 10 and 15 are never
// counted, and characters from position 19 (CNPJ) or 14 (CPF) on are
// ignored. The result carries a valid flag (both check digits match, enough
// digits, no zero first sum for CNPJ, not a repeated-digit CPF) and the
// number of counted digits, saturating at 15. The input register takes the
// character at the accepting edge, the snapshot register takes the closing
// sums once the closing character advances, and the result register then
// takes the verdict. The snapshot-to-result path holds the two reciprocal
// multiplies, one forming each sum's remainder by 11. The identifier kind
// (0 = CPF, 1 = CNPJ) is written through cfg_wr_en / cfg_wr_data and must
// only change while no identifier is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module tax_id_check_digit_validator
    import tidv_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,

    input  wire logic       cfg_wr_en,
    input  wire logic       cfg_wr_data,   // id_kind

    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,       // [7:0] char_in
    input  wire logic       s_tlast,       // last_char

    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata        // [0] id_valid, [4:1] digits_seen, [7:5] zero
);

    kind_t      kind_reg;

    // Input stage
    logic       s1_valid_reg, s1_valid_next;
    logic [7:0] s1_char_reg;
    logic       s1_last_reg;

    // Snapshot stage
    logic       s2_valid_reg, s2_valid_next;
    snap_t      s2_snap_reg;
    snap_t      snap_now;

    // Result stage
    logic       m_valid_reg, m_valid_next;
    logic       res_valid_reg;
    logic [3:0] res_digits_reg;
    logic       id_valid_now;

    logic       s_accept, s1_adv, s2_load, s2_free, out_free, out_load;

    // Advance each stage only when the stage ahead can take its item
    always_comb
    begin
        out_free = !m_valid_reg || m_tready;
        out_load = s2_valid_reg && out_free;
        s2_free  = !s2_valid_reg || out_load;
        s1_adv   = s1_valid_reg && (!s1_last_reg || s2_free);
        s2_load  = s1_adv && s1_last_reg;
        s_tready = !s1_valid_reg || s1_adv;
        s_accept = s_tvalid && s_tready;

        s1_valid_next = s_accept ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_reg);
        s2_valid_next = s2_load ? 1'b1 : (out_load ? 1'b0 : s2_valid_reg);
        m_valid_next  = out_load ? 1'b1 : (m_tready ? 1'b0 : m_valid_reg);
    end

    tidv_accum u_accum (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (s1_adv),
        .char_in   (s1_char_reg),
        .last_char (s1_last_reg),
        .kind      (kind_reg),
        .snap      (snap_now)
    );

    tidv_check u_check (
        .snap     (s2_snap_reg),
        .id_valid (id_valid_now)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg     <= KIND_CPF;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                kind_reg <= kind_t'(cfg_wr_data);
            end
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // Payload registers: load on their stage's handshake, hold otherwise
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            s1_char_reg <= s_tdata;
            s1_last_reg <= s_tlast;
        end
        if (s2_load)
        begin
            s2_snap_reg <= snap_now;
        end
        if (out_load)
        begin
            res_valid_reg  <= id_valid_now;
            res_digits_reg <= s2_snap_reg.digit_index;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {3'd0, res_digits_reg, res_valid_reg};

    // A stalled snapshot must neither drop nor change
    a_snap_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_valid_reg && !out_free) |=> (s2_valid_reg && $stable(s2_snap_reg)))
        else $error("snapshot changed while stalled");

    // A closing character always lands in the snapshot stage
    a_last_to_snap: assert property (@(posedge clk) disable iff (!rst_n)
        s2_load |=> s2_valid_reg)
        else $error("closing item lost before snapshot");

    // Backpressure only ever comes from a waiting closing character
    a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (s1_valid_reg && s1_last_reg && s2_valid_reg))
        else $error("input stalled without cause");

    // A valid identifier has at least the CPF digit count
    a_valid_digits: assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && res_valid_reg) |-> (res_digits_reg >= CPF_NEED))
        else $error("valid result with too few digits");

endmodule

`default_nettype wire
